[hdl/vdc_pkg.sv]
// Shared types and constants for the decimal Vigenere codec.
`default_nettype none
package vdc_pkg;

  localparam int KEY_MAX   = 16;
  localparam int KEY_POS_W = $clog2(KEY_MAX);
  localparam int KEY_LEN_W = KEY_POS_W + 1;
  localparam int DIGIT_CNT_W = 2;
  localparam int DIGIT_VAL_W = 10;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 64;

  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);

  localparam logic [7:0] ASCII_ZERO = 8'h30;
  localparam logic [7:0] ASCII_NINE = 8'h39;
  localparam logic [7:0] SIGN_BIAS = 8'd128;
  localparam logic [DIGIT_VAL_W-1:0] DEC_SPLIT = 10'd128;
  localparam logic [DIGIT_CNT_W-1:0] DIGITS_PER_BYTE = 2'd3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DIRECTION  = 2'd0,
    REG_KEY_LENGTH = 2'd1,
    REG_KEY_LOW    = 2'd2,
    REG_KEY_HIGH   = 2'd3
  } cfg_reg_t;

  typedef enum logic {
    KIND_ENC = 1'b0,
    KIND_DEC = 1'b1
  } kind_t;

  // One queue entry: an encrypt value (0..256) to spell out, or a decrypted byte.
  typedef struct packed {
    kind_t      kind;
    logic [8:0] value;
    logic       last;
    logic       bad;
  } q_entry_t;

endpackage
`default_nettype wire

[hdl/vdc_in_if.sv]
// Input item channel.
`default_nettype none
interface vdc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       message_last;

  modport source (output valid, output data_byte, output message_last, input ready);
  modport sink (input valid, input data_byte, input message_last, output ready);
endinterface
`default_nettype wire

[hdl/vdc_out_if.sv]
// Result item channel.
`default_nettype none
interface vdc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;
  logic       message_end;
  logic       bad_digit;

  modport source (output valid, output out_byte, output run_last, output message_end,
                  output bad_digit, input ready);
  modport sink (input valid, input out_byte, input run_last, input message_end,
                input bad_digit, output ready);
endinterface
`default_nettype wire

[hdl/vdc_cfg_if.sv]
// Configuration write channel.
`default_nettype none
interface vdc_cfg_if
  import vdc_pkg::*;
;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  reg_index;
  logic [CFG_DATA_W-1:0] wdata;

  modport source (output valid, output reg_index, output wdata, input ready);
  modport sink (input valid, input reg_index, input wdata, output ready);
endinterface
`default_nettype wire

[hdl/vdc_front.sv]
// Front end: config registers, key stepping, digit gathering, queue entry build.
`default_nettype none
module vdc_front
  import vdc_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  vdc_cfg_if.sink       cfg,
  vdc_in_if.sink        item,
  output q_entry_t      push_entry,
  output logic          push_valid,
  input  wire logic     push_ready
);

  logic                   direction;
  logic [KEY_LEN_W-1:0]   key_length;
  logic [CFG_DATA_W-1:0]  key_low;
  logic [CFG_DATA_W-1:0]  key_high;

  logic [KEY_POS_W-1:0]   key_position;
  logic [DIGIT_CNT_W-1:0] digit_count;
  logic [DIGIT_VAL_W-1:0] digit_value;
  logic                   digit_error;

  logic [KEY_POS_W-1:0]   key_position_next;
  logic [DIGIT_CNT_W-1:0] digit_count_next;
  logic [DIGIT_VAL_W-1:0] digit_value_next;
  logic                   digit_error_next;

  logic                   accept;
  logic [7:0]             key;
  logic [KEY_LEN_W-1:0]   eff_len;
  logic [KEY_LEN_W-1:0]   pos_inc;
  logic [KEY_POS_W-1:0]   pos_adv;
  logic                   is_digit;
  logic [3:0]             digit;
  logic [DIGIT_VAL_W-1:0] gathered;
  logic                   triplet_done;
  logic [7:0]             sum;
  logic [7:0]             dec_byte;

  assign cfg.ready  = 1'b1;
  assign item.ready = push_ready;
  assign accept     = item.valid && push_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      direction  <= 1'b0;
      key_length <= KEY_LEN_W'(1);
      key_low    <= '0;
      key_high   <= '0;
    end else if (cfg.valid) begin
      case (cfg_reg_t'(cfg.reg_index))
        REG_DIRECTION:  direction  <= cfg.wdata[0];
        REG_KEY_LENGTH: key_length <= cfg.wdata[KEY_LEN_W-1:0];
        REG_KEY_LOW:    key_low    <= cfg.wdata;
        REG_KEY_HIGH:   key_high   <= cfg.wdata;
        default: ;
      endcase
    end
  end

  // Key byte at the current position and the wrapped next position.
  always_comb begin
    if (key_position[KEY_POS_W-1]) begin
      key = key_high[key_position[KEY_POS_W-2:0]*8 +: 8];
    end else begin
      key = key_low[key_position[KEY_POS_W-2:0]*8 +: 8];
    end
    if (key_length == '0) begin
      eff_len = KEY_LEN_W'(1);
    end else if (key_length > KEY_LEN_W'(KEY_MAX)) begin
      eff_len = KEY_LEN_W'(KEY_MAX);
    end else begin
      eff_len = key_length;
    end
    pos_inc = {1'b0, key_position} + KEY_LEN_W'(1);
    pos_adv = (pos_inc >= eff_len) ? '0 : pos_inc[KEY_POS_W-1:0];
  end

  always_comb begin
    is_digit     = (item.data_byte >= ASCII_ZERO) && (item.data_byte <= ASCII_NINE);
    digit        = is_digit ? 4'(item.data_byte - ASCII_ZERO) : 4'd0;
    gathered     = DIGIT_VAL_W'(digit_value * DIGIT_VAL_W'(10)) + DIGIT_VAL_W'(digit);
    triplet_done = (digit_count + DIGIT_CNT_W'(1)) == DIGITS_PER_BYTE;
    sum          = item.data_byte + key;
    if (gathered > DEC_SPLIT) begin
      dec_byte = SIGN_BIAS - gathered[7:0] - key;
    end else begin
      dec_byte = gathered[7:0] - key;
    end
  end

  always_comb begin
    key_position_next = key_position;
    digit_count_next  = digit_count;
    digit_value_next  = digit_value;
    digit_error_next  = digit_error;
    push_valid        = 1'b0;
    push_entry.kind   = direction ? KIND_DEC : KIND_ENC;
    push_entry.last   = item.message_last;
    push_entry.bad    = 1'b0;
    // Negative sums are spelled as |s| + 128, i.e. 384 - sum.
    push_entry.value  = sum[7] ? (9'd384 - {1'b0, sum}) : {1'b0, sum};
    if (accept) begin
      if (!direction) begin
        push_valid        = 1'b1;
        key_position_next = pos_adv;
      end else if (triplet_done) begin
        push_valid        = 1'b1;
        push_entry.value  = {1'b0, dec_byte};
        push_entry.bad    = digit_error || !is_digit;
        key_position_next = pos_adv;
        digit_count_next  = '0;
        digit_value_next  = '0;
        digit_error_next  = 1'b0;
      end else begin
        digit_count_next = digit_count + DIGIT_CNT_W'(1);
        digit_value_next = gathered;
        digit_error_next = digit_error || !is_digit;
      end
      if (item.message_last) begin
        key_position_next = '0;
        digit_count_next  = '0;
        digit_value_next  = '0;
        digit_error_next  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key_position <= '0;
      digit_count  <= '0;
      digit_value  <= '0;
      digit_error  <= 1'b0;
    end else begin
      key_position <= key_position_next;
      digit_count  <= digit_count_next;
      digit_value  <= digit_value_next;
      digit_error  <= digit_error_next;
    end
  end

  a_count_below_three: assert property (@(posedge clk) disable iff (rst)
    digit_count != DIGITS_PER_BYTE)
    else $error("digit gathering count reached three");

  a_push_only_on_accept: assert property (@(posedge clk) disable iff (rst)
    push_valid |-> accept)
    else $error("queue push without an accepted beat");

endmodule
`default_nettype wire

[hdl/vdc_queue.sv]
// Short queue between front and back end.
`default_nettype none
module vdc_queue
  import vdc_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire q_entry_t push_entry,
  input  wire logic     push_valid,
  output logic          push_ready,
  output q_entry_t      head,
  output logic          head_valid,
  input  wire logic     pop
);

  q_entry_t              entries [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]   wr_ptr;
  logic [QUEUE_AW-1:0]   rd_ptr;
  logic [QUEUE_AW:0]     count;
  logic                  do_push;
  logic                  do_pop;

  assign push_ready = count < (QUEUE_AW+1)'(QUEUE_DEPTH);
  assign head_valid = count != '0;
  assign head       = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QUEUE_AW'(QUEUE_DEPTH-1)) ? '0 : wr_ptr + QUEUE_AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QUEUE_AW'(QUEUE_DEPTH-1)) ? '0 : rd_ptr + QUEUE_AW'(1);
      end
      count <= count + (QUEUE_AW+1)'(do_push) - (QUEUE_AW+1)'(do_pop);
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (QUEUE_AW+1)'(QUEUE_DEPTH))
    else $error("queue count above depth");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> head_valid)
    else $error("queue popped while empty");

endmodule
`default_nettype wire

[hdl/vdc_back.sv]
// Back end: splits encrypt values into digits and drives the result register.
`default_nettype none
module vdc_back
  import vdc_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire q_entry_t head,
  input  wire logic     head_valid,
  output logic          pop,
  vdc_out_if.source     result
);

  logic       work_valid;
  kind_t      work_kind;
  logic [7:0] work_chars [3];
  logic [1:0] work_idx;
  logic       work_last;
  logic       work_bad;

  logic       out_valid;
  logic [7:0] out_byte;
  logic       out_run_last;
  logic       out_message_end;
  logic       out_bad_digit;

  logic        advance;
  logic        emit;
  logic        emit_done;
  logic [1:0]  hund;
  logic [8:0]  rem_full;
  logic [6:0]  rem;
  logic [14:0] tens_prod;
  logic [3:0]  tens;
  logic [3:0]  ones;

  assign advance   = !out_valid || result.ready;
  assign emit      = work_valid && advance;
  assign emit_done = (work_kind == KIND_DEC) || (work_idx == 2'd2);
  assign pop       = head_valid && (!work_valid || (emit && emit_done));

  // Decimal split of 0..256: hundreds by compare, tens by reciprocal of 10.
  always_comb begin
    if (head.value >= 9'd200) begin
      hund = 2'd2;
    end else if (head.value >= 9'd100) begin
      hund = 2'd1;
    end else begin
      hund = 2'd0;
    end
    rem_full  = head.value - (9'(hund) * 9'd100);
    rem       = rem_full[6:0];
    tens_prod = 15'(rem) * 15'd205;
    tens      = tens_prod[14:11];
    ones      = 4'(rem - (7'(tens) * 7'd10));
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      work_kind     <= head.kind;
      work_last     <= head.last;
      work_bad      <= head.bad;
      work_idx      <= 2'd0;
      if (head.kind == KIND_ENC) begin
        work_chars[0] <= ASCII_ZERO + 8'(hund);
        work_chars[1] <= ASCII_ZERO + 8'(tens);
        work_chars[2] <= ASCII_ZERO + 8'(ones);
      end else begin
        work_chars[0] <= head.value[7:0];
        work_chars[1] <= head.value[7:0];
        work_chars[2] <= head.value[7:0];
      end
    end else if (emit) begin
      work_idx <= work_idx + 2'd1;
    end
    if (emit) begin
      out_byte        <= work_chars[work_idx];
      out_run_last    <= emit_done;
      out_message_end <= work_last;
      out_bad_digit   <= work_bad;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      work_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (pop) begin
        work_valid <= 1'b1;
      end else if (emit && emit_done) begin
        work_valid <= 1'b0;
      end
      if (advance) begin
        out_valid <= emit;
      end
    end
  end

  assign result.valid       = out_valid;
  assign result.out_byte    = out_byte;
  assign result.run_last    = out_run_last;
  assign result.message_end = out_message_end;
  assign result.bad_digit   = out_bad_digit;

  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    work_valid |-> work_idx != 2'd3)
    else $error("digit index out of range");

  a_dec_single_beat: assert property (@(posedge clk) disable iff (rst)
    (work_valid && work_kind == KIND_DEC) |-> work_idx == 2'd0)
    else $error("decrypt entry emitted more than one beat");

endmodule
`default_nettype wire

[hdl/vigenere_decimal_codec.sv]
// Top level of the decimal Vigenere codec.
// Encrypt (direction 0): each input byte is added to the current key byte and
// leaves as three ASCII decimal digits, most significant first, one result beat
// per cycle while the result port is ready; the single result port of the back
// end thus takes one input per three result beats. Decrypt (direction 1): one
// digit beat is taken per cycle while the queue has room, and every third one
// yields a byte. A two-entry queue sits between the front end (key stepping,
// digit gathering) and the back end (digit split, output register), so input
// keeps flowing while a result waits. Configuration is always ready and
// must only be written while the block is idle; there is no clearing pass.
`default_nettype none
module vigenere_decimal_codec
  import vdc_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  vdc_cfg_if.sink   cfg,
  vdc_in_if.sink    item,
  vdc_out_if.source result
);

  q_entry_t push_entry;
  logic     push_valid;
  logic     push_ready;
  q_entry_t head;
  logic     head_valid;
  logic     pop;

  vdc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item       (item),
    .push_entry (push_entry),
    .push_valid (push_valid),
    .push_ready (push_ready)
  );

  vdc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_entry (push_entry),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop)
  );

  vdc_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop),
    .result     (result)
  );

endmodule
`default_nettype wire
